@@ sv/sorted_set_merge_intersect_union_defines.svh @@
// Assertion macros for the sorted set merge block.
`ifndef SORTED_SET_MERGE_INTERSECT_UNION_DEFINES_SVH
`define SORTED_SET_MERGE_INTERSECT_UNION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSMIU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSMIU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ssmiu_pkg.sv @@
// Shared types and constants for the sorted set merge block.
`default_nettype none
package ssmiu_pkg;

    localparam int ROW_W             = 64;
    localparam int BUFFER_DEPTH_DEF  = 16;

    // Result word source select
    localparam logic [1:0] SEL_HEAD = 2'd0;
    localparam logic [1:0] SEL_ITEM = 2'd1;
    localparam logic [1:0] SEL_OVF  = 2'd2;
    localparam logic [1:0] SEL_END  = 2'd3;

    typedef struct packed {
        logic                    op;
        logic signed [ROW_W-1:0] row_value;
        logic                    has_row;
        logic                    stream_last;
    } in_word_t;

    typedef struct packed {
        logic signed [ROW_W-1:0] out_row;
        logic                    out_valid;
        logic                    set_end;
        logic                    overflow;
    } out_word_t;

    typedef struct packed {
        logic       load_item;
        logic       emit;
        logic [1:0] emit_sel;
        logic       pop;
        logic       push;
        logic       flush_all;
        logic       set_fin;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic side;
        logic fin_a;
        logic fin_b;
        logic head_lt;
        logic head_eq;
        logic out_free;
        logic op;
        logic has_row;
        logic stream_last;
        logic uni;
    } sts_t;

endpackage
`default_nettype wire

@@ sv/sorted_set_merge_intersect_union.sv @@
// A word is accepted in ST_IDLE and its row decided in ST_ROW; a row meeting pending rows of
// the other side goes to ST_CMP, which pops smaller rows in turn. An end mark passes ST_END,
// and ST_ENDO if its stream had not ended; a flush drops the rows at once in intersection and
// emits them one by one in union, and ST_DONE sends the end-of-set word. One word is in work at
// a time: a new word waits until the last is done, and an untaken result stalls the controller.
// Synchronous active-low reset clears FIFO pointers, side and end flags, mode and output valid.
`default_nettype none
`include "sorted_set_merge_intersect_union_defines.svh"
module sorted_set_merge_intersect_union #(
    parameter int BUFFER_DEPTH = ssmiu_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // mode register: 0 intersection, 1 union
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    // input word stream, A and B interleaved
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ssmiu_pkg::in_word_t  s_data,
    // result word stream
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ssmiu_pkg::out_word_t      m_data
);
    import ssmiu_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic end_emit;
    logic merge_idle;

    // Controller: walks each word through row handling, pops, end marks and flushes.
    ssmiu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: holds the word, the pending FIFO (RAM, read at the head) and
    // the result register that decouples the two channels.
    ssmiu_dp #(
        .DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // end-of-set word going out, and the merge state back at its start
    assign end_emit   = cmd.emit && (cmd.emit_sel == SEL_END);
    assign merge_idle = sts.count_zero && !sts.fin_a && !sts.fin_b;

    // Load a result word only when the output register is free.
    `SSMIU_ASSERT_NOW(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free, "result word overwritten")
    // Never pop an empty FIFO.
    `SSMIU_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, cmd.pop, !sts.count_zero, "pop on empty FIFO")
    // Never push into a full FIFO.
    `SSMIU_ASSERT_NOW(a_push_room, aclk, aresetn, cmd.push, !sts.count_full, "push on full FIFO")
    // After the end-of-set word the merge state is back to its start.
    `SSMIU_ASSERT_NEXT(a_end_clears, aclk, aresetn, end_emit, merge_idle, "set end left state")
endmodule
`default_nettype wire

@@ sv/ssmiu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssmiu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sv/ssmiu_ctrl.sv @@
// Control state machine for the sorted set merge block.
`default_nettype none
module ssmiu_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ssmiu_pkg::sts_t sts,
    output ssmiu_pkg::cmd_t     cmd
);
    import ssmiu_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROW   = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_END   = 3'd3;
    localparam logic [2:0] ST_ENDO  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       fin_s, fin_o, other_pending;
    logic [2:0] after_row;

    assign fin_s         = sts.op ? sts.fin_b : sts.fin_a;
    assign fin_o         = sts.op ? sts.fin_a : sts.fin_b;
    assign other_pending = !sts.count_zero && (sts.side != sts.op);
    assign after_row     = sts.stream_last ? ST_END : ST_IDLE;
    assign s_ready       = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_ROW;
                end
            end
            ST_ROW: begin
                if (!(sts.has_row && !fin_s)) begin
                    state_next = after_row;
                end else if (other_pending) begin
                    state_next = ST_CMP;
                end else if (fin_o) begin
                    if (!sts.uni) begin
                        state_next = after_row;
                    end else if (sts.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = SEL_ITEM;
                        state_next   = after_row;
                    end
                end else if (sts.count_full) begin
                    if (sts.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = SEL_OVF;
                        state_next   = after_row;
                    end
                end else begin
                    cmd.push   = 1'b1;
                    state_next = after_row;
                end
            end
            ST_CMP: begin
                if (!sts.count_zero && sts.head_lt) begin
                    if (!sts.uni) begin
                        cmd.pop = 1'b1;
                    end else if (sts.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = SEL_HEAD;
                        cmd.pop      = 1'b1;
                    end
                end else if (!sts.count_zero && sts.head_eq) begin
                    if (sts.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = SEL_ITEM;
                        cmd.pop      = 1'b1;
                        state_next   = after_row;
                    end
                end else if (!sts.count_zero || fin_o) begin
                    if (!sts.uni) begin
                        state_next = after_row;
                    end else if (sts.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = SEL_ITEM;
                        state_next   = after_row;
                    end
                end else begin
                    cmd.push   = 1'b1;
                    state_next = after_row;
                end
            end
            ST_END: begin
                if (sts.stream_last && !fin_s) begin
                    cmd.set_fin = 1'b1;
                    state_next  = ST_ENDO;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ENDO: begin
                if (!sts.count_zero && (sts.side != sts.op || fin_o)) begin
                    state_next = ST_FLUSH;
                end else if (fin_o) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (sts.count_zero) begin
                    state_next = ST_ENDO;
                end else if (!sts.uni) begin
                    cmd.flush_all = 1'b1;
                end else if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_HEAD;
                    cmd.pop      = 1'b1;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_END;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

@@ sv/ssmiu_dp.sv @@
// Datapath: item latch, pending row FIFO, side and end flags, result register.
`default_nettype none
module ssmiu_dp #(
    parameter int DEPTH = ssmiu_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    input  wire ssmiu_pkg::in_word_t  s_data,
    output ssmiu_pkg::out_word_t      m_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire ssmiu_pkg::cmd_t      cmd,
    output ssmiu_pkg::sts_t           sts
);
    import ssmiu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    in_word_t        item_reg;
    logic            uni_reg;
    logic            merge_mode_reg;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            side_reg, fin_a_reg, fin_b_reg;
    out_word_t       out_reg, out_word;
    logic            m_valid_reg;
    logic [ROW_W-1:0] head_row;

    ssmiu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (tail_reg),
        .wdata (item_reg.row_value),
        .raddr (head_next),
        .rdata (head_row)
    );

    // FIFO pointer and fill count update
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else if (cmd.flush_all) begin
            head_next  = tail_reg;
            count_next = '0;
        end else if (cmd.pop) begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else if (cmd.push) begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_comb begin
        out_word = '0;
        case (cmd.emit_sel)
            SEL_HEAD: begin
                out_word.out_row   = $signed(head_row);
                out_word.out_valid = 1'b1;
            end
            SEL_ITEM: begin
                out_word.out_row   = item_reg.row_value;
                out_word.out_valid = 1'b1;
            end
            SEL_OVF: begin
                out_word.overflow = 1'b1;
            end
            SEL_END: begin
                out_word.set_end = 1'b1;
            end
            default: begin
                out_word = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_mode_reg <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            side_reg       <= 1'b0;
            fin_a_reg      <= 1'b0;
            fin_b_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                merge_mode_reg <= cfg_wdata;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cmd.clear) begin
                side_reg  <= 1'b0;
                fin_a_reg <= 1'b0;
                fin_b_reg <= 1'b0;
            end else begin
                if (cmd.push) begin
                    side_reg <= item_reg.op;
                end
                if (cmd.set_fin) begin
                    if (item_reg.op) begin
                        fin_b_reg <= 1'b1;
                    end else begin
                        fin_a_reg <= 1'b1;
                    end
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
            uni_reg  <= merge_mode_reg;
        end
        if (cmd.emit) begin
            out_reg <= out_word;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    assign sts.count_zero  = (count_reg == '0);
    assign sts.count_full  = (count_reg == FULL_CNT);
    assign sts.side        = side_reg;
    assign sts.fin_a       = fin_a_reg;
    assign sts.fin_b       = fin_b_reg;
    assign sts.head_lt     = $signed(head_row) < item_reg.row_value;
    assign sts.head_eq     = $signed(head_row) == item_reg.row_value;
    assign sts.out_free    = !m_valid_reg || m_ready;
    assign sts.op          = item_reg.op;
    assign sts.has_row     = item_reg.has_row;
    assign sts.stream_last = item_reg.stream_last;
    assign sts.uni         = uni_reg;
endmodule
`default_nettype wire

@@ tb/sorted_set_merge_intersect_union_tb.sv @@
// Self-checking testbench for the sorted row-id set merge (intersection and union modes).
module sorted_set_merge_intersect_union_tb;
    import ssmiu_pkg::*;

    localparam int DEPTH = BUFFER_DEPTH_DEF;

    // stream select carried in the op field
    localparam bit SIDE_A = 1'b0;
    localparam bit SIDE_B = 1'b1;

    // mode register values
    localparam bit MODE_INTERSECT = 1'b0;
    localparam bit MODE_UNION     = 1'b1;

    localparam logic signed [ROW_W-1:0] MIN_ROW = {1'b1, {(ROW_W-1){1'b0}}};
    localparam logic signed [ROW_W-1:0] MAX_ROW = {1'b0, {(ROW_W-1){1'b1}}};

    // mode of each random phase, bit n for phase n
    localparam bit [7:0] PHASE_MODES = 8'b1010_0110;
    // phase in which the receiver backs off for a long stretch
    localparam int HOLD_PHASE  = 5;
    localparam int HOLD_CYCLES = 320;
    // quiet cycles after the last expected word, covers a full pop-and-flush pass
    localparam int DRAIN_CYCLES = 64;

    logic      aclk;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_data;

    sorted_set_merge_intersect_union #(
        .BUFFER_DEPTH(DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Words waiting to be offered, and the result words the merge must produce.
    in_word_t  input_words[$];
    out_word_t expected_results[$];

    int items_queued   = 0;
    int items_taken    = 0;
    int set_items      = 0;
    int directed_items = 0;
    int mismatch_count = 0;
    int rows_seen      = 0;
    int ends_seen      = 0;
    int ovf_seen       = 0;
    int mode_writes    = 0;

    // Shadow of the merge state: pending rows of one side, end flags, mode.
    logic signed [ROW_W-1:0] pend_rows[$];
    bit pend_side  = SIDE_A;
    bit done_a     = 1'b0;
    bit done_b     = 1'b0;
    bit union_mode = MODE_INTERSECT;

    // Sender and receiver idling.
    int tx_gap_left  = 0;
    bit tx_steady    = 1'b0;
    int rx_wait_left = 0;
    bit rx_steady    = 1'b0;
    int rx_hold_left = 0;
    bit rx_hold_req  = 1'b0;
    bit rx_hold_done = 1'b0;

    function automatic int draw_wait(bit steady);
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic bit side_done(bit side);
        return side ? done_b : done_a;
    endfunction

    function automatic void push_result(logic signed [ROW_W-1:0] row, bit valid, bit fin,
                                        bit ovf);
        out_word_t w;
        w.out_row   = row;
        w.out_valid = valid;
        w.set_end   = fin;
        w.overflow  = ovf;
        expected_results.push_back(w);
    endfunction

    // Rows still pending can no longer match: emit them in union, drop them otherwise.
    function automatic void flush_pending();
        if (union_mode == MODE_UNION) begin
            foreach (pend_rows[k]) push_result(pend_rows[k], 1'b1, 1'b0, 1'b0);
        end
        pend_rows.delete();
    endfunction

    // Advance the shadow state by one accepted input word and queue its result words.
    function automatic void predict_merge(in_word_t w);
        bit                      s   = w.op;
        bit                      o   = ~w.op;
        logic signed [ROW_W-1:0] v   = w.row_value;
        bit                      uni = (union_mode == MODE_UNION);
        bit                      matched;

        // row first
        if (w.has_row && !side_done(s)) begin
            if (pend_rows.size() > 0 && pend_side == o) begin
                // pop every smaller head of the other side
                while (pend_rows.size() > 0 && pend_rows[0] < v) begin
                    if (uni) push_result(pend_rows[0], 1'b1, 1'b0, 1'b0);
                    void'(pend_rows.pop_front());
                end
                matched = pend_rows.size() > 0 && pend_rows[0] == v;
                if (matched) begin
                    push_result(v, 1'b1, 1'b0, 1'b0);
                    void'(pend_rows.pop_front());
                end else if (pend_rows.size() > 0 || side_done(o)) begin
                    // below everything left, or nothing can come to match it
                    if (uni) push_result(v, 1'b1, 1'b0, 1'b0);
                end else begin
                    pend_rows.push_back(v);
                    pend_side = s;
                end
            end else if (side_done(o)) begin
                if (uni) push_result(v, 1'b1, 1'b0, 1'b0);
            end else if (pend_rows.size() >= DEPTH) begin
                push_result('0, 1'b0, 1'b0, 1'b1);
            end else begin
                pend_rows.push_back(v);
                pend_side = s;
            end
        end

        // then the end mark
        if (w.stream_last && !side_done(s)) begin
            if (s == SIDE_B) done_b = 1'b1;
            else             done_a = 1'b1;
            if (pend_rows.size() > 0 && pend_side == o) flush_pending();
            if (side_done(o)) begin
                flush_pending();
                push_result('0, 1'b0, 1'b1, 1'b0);
                pend_side = SIDE_A;
                done_a    = 1'b0;
                done_b    = 1'b0;
            end
        end
    endfunction

    // Driver: offer the next word once the current one is taken and the gap has run out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_merge(s_data);
                items_taken++;
            end
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                s_valid <= 1'b0;
            end else if (input_words.size() > 0) begin
                s_data  <= input_words.pop_front();
                s_valid <= 1'b1;
                // switch now and then between a steady burst and random gaps
                if ($urandom_range(0, 39) == 0) tx_steady = ~tx_steady;
                tx_gap_left = draw_wait(tx_steady);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check every taken result word against the oldest expectation, then
    // draw the stall before the next one.
    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (m_data.out_valid) rows_seen++;
                if (m_data.set_end)   ends_seen++;
                if (m_data.overflow)  ovf_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word: row %0d valid %0b end %0b ovf %0b",
                             $time, m_data.out_row, m_data.out_valid, m_data.set_end,
                             m_data.overflow);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.out_row   !== want.out_row   ||
                        m_data.out_valid !== want.out_valid ||
                        m_data.set_end   !== want.set_end   ||
                        m_data.overflow  !== want.overflow) begin
                        $display({"%0t: result mismatch: expected row %0d valid %0b end %0b ",
                                  "ovf %0b, actual row %0d valid %0b end %0b ovf %0b"},
                                 $time, want.out_row, want.out_valid, want.set_end,
                                 want.overflow, m_data.out_row, m_data.out_valid,
                                 m_data.set_end, m_data.overflow);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) rx_steady = ~rx_steady;
                rx_wait_left = draw_wait(rx_steady);
            end
            // one long back-off so the block fills up and drops s_ready
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_left = HOLD_CYCLES;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else if (rx_wait_left > 0) begin
                rx_wait_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_item(bit side, logic signed [ROW_W-1:0] row, bit has, bit ends);
        in_word_t w;
        w.op          = side;
        w.row_value   = row;
        w.has_row     = has;
        w.stream_last = ends;
        input_words.push_back(w);
        items_queued++;
    endtask

    // Write the mode register; only called while the block is idle.
    task automatic write_mode(bit mode);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        union_mode  = mode;
        mode_writes++;
    endtask

    // Hold until every word is taken and every expected result has arrived, then
    // let the block finish any silent work.
    task automatic wait_idle();
        while (items_taken != items_queued || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Hand-picked walk through the merge cases; the tail adds a flush at end of A.
    task automatic queue_directed(bit with_flush);
        add_item(SIDE_B, {$urandom, $urandom}, 1'b0, 1'b0); // idle word: no row, no end
        add_item(SIDE_A, MIN_ROW, 1'b1, 1'b0);
        add_item(SIDE_A, -64'sd1, 1'b1, 1'b0);
        add_item(SIDE_A, 64'sd0, 1'b1, 1'b0);
        add_item(SIDE_B, MIN_ROW, 1'b1, 1'b0);  // equals the pending head
        add_item(SIDE_B, 64'sd3, 1'b1, 1'b0);   // pops -1 and 0, then waits
        add_item(SIDE_A, 64'sd1, 1'b1, 1'b0);   // below every pending B row
        add_item(SIDE_B, 64'sd4, 1'b1, 1'b0);   // same side: append
        add_item(SIDE_A, 64'sd4, 1'b1, 1'b1);   // pops 3, matches 4, ends A
        add_item(SIDE_A, 64'sd9, 1'b1, 1'b0);   // A already ended: ignored
        add_item(SIDE_B, 64'sd5, 1'b1, 1'b0);   // A ended, nothing pending
        add_item(SIDE_B, MAX_ROW, 1'b1, 1'b1);  // ends B: set end
        if (with_flush) begin
            add_item(SIDE_B, 64'sd5, 1'b1, 1'b0);
            add_item(SIDE_B, 64'sd6, 1'b1, 1'b0);
            add_item(SIDE_A, {$urandom, $urandom}, 1'b0, 1'b1); // end-only A flushes B
            add_item(SIDE_B, MAX_ROW, 1'b1, 1'b1);
        end
    endtask

    // Build one well-formed pair of ascending streams over a shared walk of row ids,
    // interleave them, taking A with a chance of bias_a percent, and sprinkle noise if asked.
    task automatic queue_set_pair(int steps, int spread, int bias_a, bit noisy);
        logic signed [ROW_W-1:0] walk;
        logic signed [ROW_W-1:0] rows_a[$];
        logic signed [ROW_W-1:0] rows_b[$];
        int  i;
        int  ia;
        int  ib;
        bit  a_ended;
        bit  b_ended;
        bit  a_sep;
        bit  b_sep;
        bit  take_a;
        bit  ends;
        bit  side;

        case ($urandom_range(0, 5))
            0:       walk = MIN_ROW;
            1:       walk = MAX_ROW - steps * spread;
            2:       walk = -64'sd20 + $urandom_range(0, 40);
            default: walk = {$urandom, $urandom};
        endcase
        for (i = 0; i < steps; i++) begin
            case ($urandom_range(0, 3))
                0:       rows_a.push_back(walk);
                1:       rows_b.push_back(walk);
                default: begin
                    rows_a.push_back(walk);
                    rows_b.push_back(walk);
                end
            endcase
            walk = walk + $urandom_range(1, spread);
        end

        // end each stream on its last row or with a separate end-only word
        a_sep   = (rows_a.size() == 0) || $urandom_range(0, 1);
        b_sep   = (rows_b.size() == 0) || $urandom_range(0, 1);
        ia      = 0;
        ib      = 0;
        a_ended = 1'b0;
        b_ended = 1'b0;
        while (!a_ended || !b_ended) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0: add_item(1'($urandom_range(0, 1)), {$urandom, $urandom}, 1'b0, 1'b0);
                    1: begin
                        // stray word for a stream that has already ended
                        if (a_ended || b_ended)
                            add_item(a_ended ? SIDE_A : SIDE_B, {$urandom, $urandom},
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                    default: begin
                        // out-of-order row on a stream still running
                        side = a_ended ? SIDE_B
                                       : (b_ended ? SIDE_A : 1'($urandom_range(0, 1)));
                        add_item(side, {$urandom, $urandom}, 1'b1, 1'b0);
                    end
                endcase
            end
            take_a = b_ended || (!a_ended && $urandom_range(0, 99) < bias_a);
            if (take_a) begin
                if (ia < rows_a.size()) begin
                    ends = (ia == rows_a.size() - 1) && !a_sep;
                    add_item(SIDE_A, rows_a[ia], 1'b1, ends);
                    ia++;
                end else begin
                    ends = 1'b1;
                    add_item(SIDE_A, {$urandom, $urandom}, 1'b0, 1'b1);
                end
                a_ended = ends;
            end else begin
                if (ib < rows_b.size()) begin
                    ends = (ib == rows_b.size() - 1) && !b_sep;
                    add_item(SIDE_B, rows_b[ib], 1'b1, ends);
                    ib++;
                end else begin
                    ends = 1'b1;
                    add_item(SIDE_B, {$urandom, $urandom}, 1'b0, 1'b1);
                end
                b_ended = ends;
            end
            set_items++;
        end
    endtask

    initial begin : stimulus
        int phase;
        int target;
        int pick;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed walk in both modes
        write_mode(MODE_INTERSECT);
        queue_directed(1'b0);
        wait_idle();
        write_mode(MODE_UNION);
        queue_directed(1'b1);
        directed_items = items_queued;
        wait_idle();

        // random phases, mode changed only between them
        for (phase = 0; phase < 8; phase++) begin
            write_mode(PHASE_MODES[phase]);
            if (phase == HOLD_PHASE) rx_hold_req <= 1'b1;
            target = set_items + 18;
            // one side runs far ahead: fill the pending buffer past its depth
            if (phase == 0) queue_set_pair(32, 3, 100, 1'b0);
            while (set_items < target) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    queue_set_pair($urandom_range(14, 24), $urandom_range(1, 3),
                                   $urandom_range(70, 100), 1'b1);
                else
                    queue_set_pair($urandom_range(1, 8),
                                   pick < 6 ? $urandom_range(1, 3) : $urandom_range(1, 1 << 20),
                                   $urandom_range(20, 80), pick > 6);
            end
            wait_idle();
        end

        $display("covered %0d input words (%0d directed) over %0d mode writes, with a %0d-cycle",
                 items_queued, directed_items, mode_writes, HOLD_CYCLES);
        $display("output back-off; checked %0d rows, %0d set ends, %0d overflow drops",
                 rows_seen, ends_seen, ovf_seen);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: give up well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sorted_set_merge_intersect_union.f @@
+incdir+sv
sv/ssmiu_pkg.sv
sv/ssmiu_ram.sv
sv/ssmiu_ctrl.sv
sv/ssmiu_dp.sv
sv/sorted_set_merge_intersect_union.sv
tb/sorted_set_merge_intersect_union_tb.sv
